>>> rtl/i2c_slave_buffer_controller_defines.svh
// ----------------------------------------------------------------------------
// i2c slave buffer controller assertion macros
// shared property forms for the checker of the buffered i2c slave controller
// ----------------------------------------------------------------------------
`ifndef I2C_SLAVE_BUFFER_CONTROLLER_DEFINES_SVH
`define I2C_SLAVE_BUFFER_CONTROLLER_DEFINES_SVH

// same-cycle implication
`define SBC_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define SBC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> rtl/i2csbc_pkg.sv
// ----------------------------------------------------------------------------
// i2csbc_pkg
// types and codes of the buffered i2c slave transfer controller
// ----------------------------------------------------------------------------
`default_nettype none

package i2csbc_pkg;

   typedef enum logic [1:0] {
      REQ_LOAD  = 2'd0,
      REQ_ARM   = 2'd1,
      REQ_READ  = 2'd2,
      REQ_EVENT = 2'd3
   } req_kind_type;

   typedef enum logic [1:0] {
      CMD_NONE          = 2'd0,
      CMD_CONTINUE      = 2'd1,
      CMD_COMPLETE      = 2'd2,
      CMD_COMPLETE_NACK = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      STAT_NONE    = 2'd0,
      STAT_RX_DATA = 2'd1,
      STAT_TX_OK   = 2'd2
   } stat_type;

   typedef struct packed {
      logic [1:0] req_type;
      logic [3:0] index;
      logic [7:0] data;
      logic [4:0] msg_size;
      logic [7:0] raw_status;
      logic       bus_error;
      logic       addr_stop_event;
      logic       data_event;
      logic       collision;
      logic       is_address;
      logic       master_reads;
      logic       master_nacked;
   } req_item_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       out_byte_valid;
      logic [1:0] bus_command;
      logic       busy_flag;
      logic [1:0] transfer_status;
      logic [7:0] error_value;
      logic       armed_flag;
   } rsp_item_type;

endpackage

`default_nettype wire

>>> rtl/i2c_slave_buffer_controller.sv
// ----------------------------------------------------------------------------
// i2c_slave_buffer_controller
// buffered i2c slave transfer controller with a synchronous message buffer
// ----------------------------------------------------------------------------
// Usage:
// - req_* carries host requests (load, arm, read) and decoded bus events;
//   rsp_* returns exactly one result per request, in order.
// - a transfer happens on a clock edge with valid high and stall low.
// - a result's control fields and buffer read are registered on its request
//   transfer in the buffer-read stage and move on into the output register,
//   which drives rsp_valid; a stall on rsp_stall holds them where they are.
// - throughput: one request per cycle while req_stall is low; every request
//   is at most one buffer access, and the control registers update on the
//   request transfer itself, so successive requests never wait on each other.
// - when rsp_stall holds, one result waits in the output register and one
//   more in the buffer-read stage; req_stall rises only when both are full.
// - reset (synchronous) clears the pointer, expected size, status, error,
//   busy and armed state and empties the pipeline; the buffer contents are
//   not cleared and must be loaded before they are read.
// ----------------------------------------------------------------------------
`default_nettype none

module i2c_slave_buffer_controller
   import i2csbc_pkg::*;
#(
   parameter int BUF_DEPTH = 16
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_valid,
   output logic              req_stall,
   input  wire req_item_type req_item,
   output logic              rsp_valid,
   input  wire logic         rsp_stall,
   output rsp_item_type      rsp_item
);

   localparam int AW = (BUF_DEPTH > 1) ? $clog2(BUF_DEPTH) : 1;
   localparam int PW = $clog2(BUF_DEPTH + 1);
   localparam int CW = ((PW > 5) ? PW : 5) + 1;
   localparam logic [PW-1:0] DEPTH_P = PW'(BUF_DEPTH);

   // control state
   logic [PW-1:0] ptr_ff, ptr_in;
   logic [4:0]    exp_size_ff, exp_size_in;
   logic [1:0]    status_ff, status_in;
   logic [7:0]    error_ff, error_in;
   logic          busy_ff, busy_in;
   logic          armed_ff, armed_in;

   // buffer memory
   logic [7:0]    buf_mem [BUF_DEPTH];
   logic [7:0]    rd_data_ff;
   logic          mem_we, mem_re;
   logic [AW-1:0] mem_waddr, mem_raddr;

   // pipeline
   logic          s1_valid_ff, s1_valid_in;
   rsp_item_type  s1_item_ff, s1_item_in;
   logic          rsp_valid_ff, rsp_valid_in;
   rsp_item_type  rsp_item_ff, rsp_item_in;

   logic          accept, s1_advance, idx_ok;
   logic [PW-1:0] ptr_inc;
   logic [1:0]    cmd;
   logic          byte_valid;

   assign s1_advance = s1_valid_ff & (~rsp_valid_ff | ~rsp_stall);
   assign req_stall  = s1_valid_ff & rsp_valid_ff & rsp_stall;
   assign accept     = req_valid & ~req_stall;
   assign idx_ok     = 32'(req_item.index) < BUF_DEPTH;
   assign ptr_inc    = ptr_ff + PW'(1);

   always_comb begin
      ptr_in      = ptr_ff;
      exp_size_in = exp_size_ff;
      status_in   = status_ff;
      error_in    = error_ff;
      busy_in     = busy_ff;
      armed_in    = armed_ff;
      mem_we      = 1'b0;
      mem_re      = 1'b0;
      mem_waddr   = AW'(req_item.index);
      mem_raddr   = AW'(req_item.index);
      cmd         = CMD_NONE;
      byte_valid  = 1'b0;
      case (req_kind_type'(req_item.req_type))
         REQ_LOAD: begin
            mem_we = accept & ~busy_ff & idx_ok;
         end
         REQ_ARM: begin
            if (!busy_ff) begin
               exp_size_in = req_item.msg_size;
               status_in   = STAT_NONE;
               error_in    = 8'd0;
               busy_in     = 1'b1;
               armed_in    = 1'b1;
            end
         end
         REQ_READ: begin
            byte_valid = idx_ok;
            mem_re     = accept & idx_ok;
         end
         REQ_EVENT: begin
            if (!armed_ff) begin
               cmd = CMD_NONE;
            end else if (req_item.bus_error) begin
               error_in = req_item.raw_status;
               busy_in  = 1'b0;
               cmd      = CMD_CONTINUE;
            end else if (req_item.addr_stop_event && !req_item.data_event) begin
               if (req_item.collision) begin
                  busy_in  = 1'b0;
                  error_in = req_item.raw_status;
                  ptr_in   = '0;
                  cmd      = CMD_COMPLETE;
               end else if (req_item.is_address) begin
                  busy_in = 1'b1;
                  ptr_in  = '0;
                  cmd     = CMD_CONTINUE;
               end else begin
                  busy_in  = 1'b0;
                  armed_in = 1'b0;
                  cmd      = CMD_COMPLETE;
               end
            end else if (req_item.data_event && !req_item.addr_stop_event) begin
               if (req_item.master_reads) begin
                  if ((req_item.master_nacked && ptr_ff != '0) || ptr_ff >= DEPTH_P) begin
                     if (CW'(ptr_ff) == CW'(exp_size_ff)) begin
                        status_in = STAT_TX_OK;
                     end else begin
                        error_in = req_item.raw_status;
                     end
                     cmd = CMD_COMPLETE;
                  end else begin
                     mem_re     = accept;
                     mem_raddr  = AW'(ptr_ff);
                     byte_valid = 1'b1;
                     ptr_in     = ptr_inc;
                     cmd        = CMD_CONTINUE;
                  end
               end else if (ptr_ff >= DEPTH_P) begin
                  ptr_in = '0;
                  cmd    = CMD_COMPLETE_NACK;
               end else begin
                  mem_we    = accept;
                  mem_waddr = AW'(ptr_ff);
                  status_in = STAT_RX_DATA;
                  // stop after one byte past the expected size or at the buffer end
                  if (CW'(ptr_inc) == CW'(exp_size_ff) + CW'(1) || ptr_inc == DEPTH_P) begin
                     ptr_in = '0;
                     cmd    = CMD_COMPLETE_NACK;
                  end else begin
                     ptr_in = ptr_inc;
                     cmd    = CMD_CONTINUE;
                  end
               end
            end
         end
         default: begin
            cmd = CMD_NONE;
         end
      endcase
   end

   always_comb begin
      s1_item_in                 = s1_item_ff;
      s1_item_in.out_byte        = 8'd0;
      s1_item_in.out_byte_valid  = byte_valid;
      s1_item_in.bus_command     = cmd;
      s1_item_in.busy_flag       = busy_in;
      s1_item_in.transfer_status = status_in;
      s1_item_in.error_value     = error_in;
      s1_item_in.armed_flag      = armed_in;

      rsp_item_in          = s1_item_ff;
      rsp_item_in.out_byte = s1_item_ff.out_byte_valid ? rd_data_ff : 8'd0;

      s1_valid_in  = accept | (s1_valid_ff & ~s1_advance);
      rsp_valid_in = s1_advance | (rsp_valid_ff & rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ptr_ff       <= '0;
         exp_size_ff  <= '0;
         status_ff    <= STAT_NONE;
         error_ff     <= '0;
         busy_ff      <= 1'b0;
         armed_ff     <= 1'b0;
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (accept) begin
            ptr_ff      <= ptr_in;
            exp_size_ff <= exp_size_in;
            status_ff   <= status_in;
            error_ff    <= error_in;
            busy_ff     <= busy_in;
            armed_ff    <= armed_in;
         end
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_item_ff <= s1_item_in;
      end
      if (s1_advance) begin
         rsp_item_ff <= rsp_item_in;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         buf_mem[mem_waddr] <= req_item.data;
      end
      if (mem_re) begin
         rd_data_ff <= buf_mem[mem_raddr];
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;

endmodule

`default_nettype wire

>>> rtl/i2csbc_checker.sv
// ----------------------------------------------------------------------------
// i2csbc_checker
// port-level checks of the buffered i2c slave transfer controller
// ----------------------------------------------------------------------------
`default_nettype none

`include "i2c_slave_buffer_controller_defines.svh"

module i2csbc_checker
   import i2csbc_pkg::*;
(
   input wire logic         clock,
   input wire logic         reset,
   input wire logic         req_valid,
   input wire logic         req_stall,
   input wire req_item_type req_item,
   input wire logic         rsp_valid,
   input wire logic         rsp_stall,
   input wire rsp_item_type rsp_item
);

   logic req_seen;
   assign req_seen = req_valid | req_stall | (req_item.req_type == REQ_EVENT);

   `SBC_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_item), "result changed while stalled")
   `SBC_ASSERT_NEXT(a_reset_empty, clock, 1'b0, reset, !rsp_valid && !req_stall, "pipeline not empty after reset")
   `SBC_ASSERT_NOW(a_byte_zero, clock, reset, rsp_valid && !rsp_item.out_byte_valid, rsp_item.out_byte == 8'd0, "byte not zero without valid")
   `SBC_ASSERT_NOW(a_byte_cmd, clock, reset, rsp_valid && rsp_item.out_byte_valid && req_seen | !req_seen, rsp_item.bus_command == CMD_NONE || rsp_item.bus_command == CMD_CONTINUE || !rsp_item.out_byte_valid, "byte sent with a completing command")

endmodule

bind i2c_slave_buffer_controller i2csbc_checker u_i2csbc_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .req_item  (req_item),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_item  (rsp_item)
);

`default_nettype wire

>>> tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench for i2c_slave_buffer_controller
// runs a stimulus table, then random host requests and bus event sequences,
// with sender gaps and receiver stalls; every result is compared field by field
// with an in-order queue from the table or a cycle-free model of the controller
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module testbench;
   import i2csbc_pkg::*;

   localparam int BUF_DEPTH    = 16;
   localparam int RANDOM_ITEMS = 1200;
   localparam int HOLD_CYCLES  = 40;

   typedef struct packed {
      req_item_type it;
      logic         typed;
      rsp_item_type want;
   } stim_row_type;

   logic         clock;
   logic         reset;
   logic         req_valid;
   logic         req_stall;
   req_item_type req_item;
   logic         rsp_valid;
   logic         rsp_stall;
   rsp_item_type rsp_item;

   // model of the controller
   logic [7:0]   buf_mem [BUF_DEPTH];
   bit           buf_written [BUF_DEPTH];
   logic [4:0]   ptr;
   logic [4:0]   want_size;
   stat_type     stat;
   logic [7:0]   err;
   logic         busy;
   logic         armed;

   rsp_item_type pending_results[$];
   stim_row_type stim_rows[$];
   int           mismatches;
   int           results_seen;
   int           burst_left;
   int           seq_left;
   bit           seq_reads;
   bit           hold_now;
   bit           drv_typed;
   rsp_item_type drv_want;

   i2c_slave_buffer_controller #(.BUF_DEPTH(BUF_DEPTH)) DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_item  (req_item),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_item  (rsp_item)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   initial begin
      #4_000_000;
      $display("** i2c_slave_buffer_controller: FAILED **");
      $finish;
   end

   task automatic report_mismatch(input string msg);
      if (mismatches < 100) begin
         $display("mismatch at result %0d: %s", results_seen, msg);
      end
      mismatches++;
   endtask

   task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
      if (got !== want) begin
         report_mismatch($sformatf("%s expected 0x%0h, got 0x%0h", name, want, got));
      end
   endtask

   function automatic req_item_type host_item(req_kind_type kind, logic [3:0] idx,
                                              logic [7:0] data, logic [4:0] size);
      req_item_type it;
      it = '0;
      it.req_type = kind;
      it.index    = idx;
      it.data     = data;
      it.msg_size = size;
      return it;
   endfunction

   function automatic req_item_type bus_item(logic berr, logic as_ev, logic d_ev, logic coll,
                                             logic is_addr, logic mreads, logic nacked,
                                             logic [7:0] raw, logic [7:0] data);
      req_item_type it;
      it = '0;
      it.req_type        = REQ_EVENT;
      it.bus_error       = berr;
      it.addr_stop_event = as_ev;
      it.data_event      = d_ev;
      it.collision       = coll;
      it.is_address      = is_addr;
      it.master_reads    = mreads;
      it.master_nacked   = nacked;
      it.raw_status      = raw;
      it.data            = data;
      return it;
   endfunction

   function automatic rsp_item_type rsp_of(logic [7:0] ob, logic ov, cmd_type cmd, logic b,
                                           stat_type s, logic [7:0] e, logic a);
      rsp_item_type r;
      r.out_byte        = ob;
      r.out_byte_valid  = ov;
      r.bus_command     = cmd;
      r.busy_flag       = b;
      r.transfer_status = s;
      r.error_value     = e;
      r.armed_flag      = a;
      return r;
   endfunction

   // applies one transfer to the model and returns the result it causes
   task automatic compute_response(input req_item_type it, output rsp_item_type r);
      cmd_type cmd;
      r   = '0;
      cmd = CMD_NONE;
      case (it.req_type)
         REQ_LOAD: begin
            if (!busy) begin
               buf_mem[it.index]     = it.data;
               buf_written[it.index] = 1'b1;
            end
         end
         REQ_ARM: begin
            if (!busy) begin
               want_size = it.msg_size;
               stat      = STAT_NONE;
               err       = 8'h00;
               busy      = 1'b1;
               armed     = 1'b1;
            end
         end
         REQ_READ: begin
            r.out_byte       = buf_mem[it.index];
            r.out_byte_valid = 1'b1;
         end
         default: begin
            if (!armed) begin
               cmd = CMD_NONE;
            end else if (it.bus_error) begin
               err  = it.raw_status;
               busy = 1'b0;
               cmd  = CMD_CONTINUE;
            end else if (it.addr_stop_event && !it.data_event) begin
               if (it.collision) begin
                  busy = 1'b0;
                  err  = it.raw_status;
                  ptr  = '0;
                  cmd  = CMD_COMPLETE;
               end else if (it.is_address) begin
                  busy = 1'b1;
                  ptr  = '0;
                  cmd  = CMD_CONTINUE;
               end else begin
                  busy  = 1'b0;
                  armed = 1'b0;
                  cmd   = CMD_COMPLETE;
               end
            end else if (it.data_event && !it.addr_stop_event) begin
               if (it.master_reads) begin
                  if ((it.master_nacked && ptr != 0) || ptr >= BUF_DEPTH) begin
                     if (ptr == want_size) stat = STAT_TX_OK;
                     else err = it.raw_status;
                     cmd = CMD_COMPLETE;
                  end else begin
                     r.out_byte       = buf_mem[ptr[3:0]];
                     r.out_byte_valid = 1'b1;
                     ptr              = ptr + 5'd1;
                     cmd              = CMD_CONTINUE;
                  end
               end else if (ptr >= BUF_DEPTH) begin
                  // no room left: byte dropped
                  ptr = '0;
                  cmd = CMD_COMPLETE_NACK;
               end else begin
                  buf_mem[ptr[3:0]]     = it.data;
                  buf_written[ptr[3:0]] = 1'b1;
                  ptr                   = ptr + 5'd1;
                  stat                  = STAT_RX_DATA;
                  if ({1'b0, ptr} == {1'b0, want_size} + 6'd1 || ptr == BUF_DEPTH) begin
                     ptr = '0;
                     cmd = CMD_COMPLETE_NACK;
                  end else begin
                     cmd = CMD_CONTINUE;
                  end
               end
            end
         end
      endcase
      r.bus_command     = cmd;
      r.busy_flag       = busy;
      r.transfer_status = stat;
      r.error_value     = err;
      r.armed_flag      = armed;
   endtask

   // steer clear of reading buffer entries that were never written
   function automatic req_item_type keep_defined(req_item_type it);
      if (it.req_type == REQ_READ && !buf_written[it.index]) it.req_type = REQ_LOAD;
      if (it.req_type == REQ_EVENT && armed && !it.bus_error && it.data_event &&
          !it.addr_stop_event && it.master_reads &&
          !((it.master_nacked && ptr != 0) || ptr >= BUF_DEPTH) &&
          !buf_written[ptr[3:0]]) begin
         it.master_reads = 1'b0;
      end
      return it;
   endfunction

   function automatic bit is_ignored(req_item_type it);
      return ((it.req_type == REQ_LOAD || it.req_type == REQ_ARM) && busy) ||
             (it.req_type == REQ_EVENT && !armed);
   endfunction

   function automatic logic [4:0] pick_size();
      int r;
      r = $urandom_range(0, 9);
      if (r < 5) return 5'($urandom_range(0, 6));
      if (r < 8) return 5'($urandom_range(7, 16));
      return 5'($urandom_range(17, 31));
   endfunction

   // host requests while disarmed, else mostly well-formed bus sequences with random content, some noise
   function automatic req_item_type gen_item();
      req_item_type it;
      logic [63:0]  bits;
      int           pick;
      bits = {$urandom, $urandom};
      it   = bits[$bits(req_item_type)-1:0];
      pick = $urandom_range(0, 99);
      if (!armed) begin
         seq_left = 0;
         if (pick < 45) it.req_type = REQ_LOAD;
         else if (pick < 65) it.req_type = REQ_READ;
         else if (pick < 93) begin
            it.req_type = REQ_ARM;
            it.msg_size = pick_size();
         end else it.req_type = REQ_EVENT;
      end else if (pick < 12) begin
         it.req_type = 2'($urandom_range(0, 3));
      end else begin
         it.req_type  = REQ_EVENT;
         it.bus_error = ($urandom_range(0, 49) == 0);
         it.collision = ($urandom_range(0, 39) == 0);
         if (seq_left == 0) begin
            it.addr_stop_event = 1'b1;
            it.data_event      = 1'b0;
            if (!busy || $urandom_range(0, 2) == 0) begin
               it.is_address = 1'b1;
               seq_left      = $urandom_range(1, 18);
               seq_reads     = $urandom_range(0, 1);
            end else begin
               it.is_address = 1'b0;
            end
         end else begin
            it.addr_stop_event = 1'b0;
            it.data_event      = 1'b1;
            it.master_reads    = seq_reads ^ ($urandom_range(0, 9) == 0);
            if (seq_reads && seq_left == 1) it.master_nacked = ($urandom_range(0, 3) != 0);
            else it.master_nacked = ($urandom_range(0, 15) == 0);
            seq_left--;
         end
      end
      return it;
   endfunction

   task automatic pace();
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         if (gap != 0) begin
            @(negedge clock);
            req_valid <= 1'b0;
            repeat (gap - 1) @(negedge clock);
         end
         burst_left = $urandom_range(1, ($urandom_range(0, 4) == 0) ? 60 : 12);
      end
      burst_left--;
   endtask

   // called right after a falling edge; returns once the transfer is taken
   task automatic offer(input req_item_type it);
      req_item  <= it;
      req_valid <= 1'b1;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   always @(posedge clock) begin
      rsp_item_type r;
      rsp_item_type want;
      if (!reset) begin
         if (req_valid && !req_stall) begin
            compute_response(req_item, r);
            pending_results.push_back(drv_typed ? drv_want : r);
         end
         if (rsp_valid && !rsp_stall) begin
            if (pending_results.size() == 0) begin
               report_mismatch("result with no transfer pending");
            end else begin
               want = pending_results.pop_front();
               check_field("out_byte", want.out_byte, rsp_item.out_byte);
               check_field("out_byte_valid", 8'(want.out_byte_valid),
                           8'(rsp_item.out_byte_valid));
               check_field("bus_command", 8'(want.bus_command), 8'(rsp_item.bus_command));
               check_field("busy_flag", 8'(want.busy_flag), 8'(rsp_item.busy_flag));
               check_field("transfer_status", 8'(want.transfer_status),
                           8'(rsp_item.transfer_status));
               check_field("error_value", want.error_value, rsp_item.error_value);
               check_field("armed_flag", 8'(want.armed_flag), 8'(rsp_item.armed_flag));
            end
            results_seen++;
         end
      end
   end

   // receiver: stall patterns of changing style, plus one long hold-off
   initial begin
      int mode;
      int len;
      int cyc;
      rsp_stall <= 1'b0;
      cyc = 0;
      forever begin
         if (hold_now) begin
            hold_now = 1'b0;
            repeat (HOLD_CYCLES) begin
               @(negedge clock);
               rsp_stall <= 1'b1;
            end
         end
         mode = $urandom_range(0, 3);
         len  = $urandom_range(10, 80);
         for (int i = 0; i < len && !hold_now; i++) begin
            @(negedge clock);
            cyc++;
            case (mode)
               0: rsp_stall <= 1'b0;
               1: rsp_stall <= ($urandom_range(0, 9) < 3);
               2: rsp_stall <= ($urandom_range(0, 3) != 0);
               default: rsp_stall <= (cyc % 3 == 0);
            endcase
         end
      end
   end

   initial begin
      req_item_type it;
      rsp_item_type zero_rsp;
      rsp_item_type armed_rsp;
      int           counted;
      reset      <= 1'b1;
      req_valid  <= 1'b0;
      req_item   <= '0;
      ptr         = '0;
      want_size   = '0;
      stat        = STAT_NONE;
      err         = 8'h00;
      busy        = 1'b0;
      armed       = 1'b0;
      mismatches  = 0;
      burst_left  = 0;
      seq_left    = 0;
      hold_now    = 1'b0;
      drv_typed   = 1'b0;
      drv_want    = '0;
      for (int i = 0; i < BUF_DEPTH; i++) begin
         buf_mem[i]     = 8'h00;
         buf_written[i] = 1'b0;
      end
      zero_rsp  = rsp_of(8'h00, 1'b0, CMD_NONE, 1'b0, STAT_NONE, 8'h00, 1'b0);
      armed_rsp = rsp_of(8'h00, 1'b0, CMD_NONE, 1'b1, STAT_NONE, 8'h00, 1'b1);

      // event while disarmed, loads and reads at the index and data extremes
      stim_rows.push_back('{bus_item(0, 0, 1, 0, 0, 0, 0, 8'h00, 8'h00), 1'b1, zero_rsp});
      stim_rows.push_back('{host_item(REQ_LOAD, 4'd0, 8'hFF, 5'd0), 1'b1, zero_rsp});
      stim_rows.push_back('{host_item(REQ_LOAD, 4'd15, 8'h00, 5'd0), 1'b1, zero_rsp});
      stim_rows.push_back('{host_item(REQ_LOAD, 4'd1, 8'h5A, 5'd0), 1'b1, zero_rsp});
      stim_rows.push_back('{host_item(REQ_READ, 4'd0, 8'h00, 5'd0), 1'b1,
                            rsp_of(8'hFF, 1'b1, CMD_NONE, 1'b0, STAT_NONE, 8'h00, 1'b0)});
      stim_rows.push_back('{host_item(REQ_READ, 4'd15, 8'h00, 5'd0), 1'b1,
                            rsp_of(8'h00, 1'b1, CMD_NONE, 1'b0, STAT_NONE, 8'h00, 1'b0)});
      // arm, then load and arm while busy are dropped
      stim_rows.push_back('{host_item(REQ_ARM, 4'd0, 8'h00, 5'd2), 1'b1, armed_rsp});
      stim_rows.push_back('{host_item(REQ_LOAD, 4'd0, 8'h12, 5'd0), 1'b1, armed_rsp});
      stim_rows.push_back('{host_item(REQ_ARM, 4'd0, 8'h00, 5'd31), 1'b1, armed_rsp});
      // master read of two bytes, nack at the expected size
      stim_rows.push_back('{bus_item(0, 1, 0, 0, 1, 1, 0, 8'h00, 8'h00), 1'b0, '0});
      stim_rows.push_back('{bus_item(0, 0, 1, 0, 0, 1, 0, 8'h00, 8'h00), 1'b0, '0});
      stim_rows.push_back('{bus_item(0, 0, 1, 0, 0, 1, 0, 8'h00, 8'h00), 1'b0, '0});
      stim_rows.push_back('{bus_item(0, 0, 1, 0, 0, 1, 1, 8'h3C, 8'h00), 1'b0, '0});
      // ambiguous event flags, then bus error, collision and stop
      stim_rows.push_back('{bus_item(0, 1, 1, 0, 1, 1, 0, 8'h11, 8'h22), 1'b0, '0});
      stim_rows.push_back('{bus_item(0, 0, 0, 0, 0, 0, 0, 8'h11, 8'h22), 1'b0, '0});
      stim_rows.push_back('{bus_item(1, 0, 0, 0, 0, 0, 0, 8'hFF, 8'h00), 1'b1,
                            rsp_of(8'h00, 1'b0, CMD_CONTINUE, 1'b0, STAT_TX_OK, 8'hFF, 1'b1)});
      stim_rows.push_back('{bus_item(0, 1, 0, 1, 1, 0, 0, 8'h80, 8'h00), 1'b0, '0});
      stim_rows.push_back('{bus_item(0, 1, 0, 0, 0, 0, 0, 8'h00, 8'h00), 1'b0, '0});
      // oversized expected size, master write
      stim_rows.push_back('{host_item(REQ_ARM, 4'd0, 8'h00, 5'd31), 1'b1, armed_rsp});
      stim_rows.push_back('{bus_item(0, 1, 0, 0, 1, 0, 0, 8'h00, 8'h00), 1'b0, '0});
      stim_rows.push_back('{bus_item(0, 0, 1, 0, 0, 0, 0, 8'h00, 8'hA5), 1'b0, '0});
      stim_rows.push_back('{bus_item(0, 0, 1, 1, 1, 0, 1, 8'hFF, 8'h00), 1'b0, '0});
      stim_rows.push_back('{bus_item(0, 1, 0, 0, 0, 0, 0, 8'h00, 8'h00), 1'b0, '0});
      // size zero: nack on the first received byte
      stim_rows.push_back('{host_item(REQ_ARM, 4'd0, 8'h00, 5'd0), 1'b1, armed_rsp});
      stim_rows.push_back('{bus_item(0, 1, 0, 0, 1, 0, 0, 8'h00, 8'h00), 1'b0, '0});
      stim_rows.push_back('{bus_item(0, 0, 1, 0, 0, 0, 0, 8'h00, 8'h3C), 1'b0, '0});
      stim_rows.push_back('{bus_item(0, 1, 0, 0, 0, 0, 0, 8'h00, 8'h00), 1'b0, '0});

      repeat (4) @(negedge clock);
      reset <= 1'b0;

      foreach (stim_rows[i]) begin
         pace();
         @(negedge clock);
         drv_typed = stim_rows[i].typed;
         drv_want  = stim_rows[i].want;
         offer(stim_rows[i].it);
      end

      drv_typed = 1'b0;
      hold_now  = 1'b1;
      counted   = 0;
      while (counted < RANDOM_ITEMS) begin
         pace();
         @(negedge clock);
         it = keep_defined(gen_item());
         if (!is_ignored(it)) counted++;
         offer(it);
      end

      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (mismatches == 0) begin
         $display("** i2c_slave_buffer_controller: PASSED **");
      end else begin
         $display("** i2c_slave_buffer_controller: FAILED **");
      end
      $finish;
   end

endmodule
